>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of the project.
// Each expects a clk and an active-low arst_n in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

>>> hw/rtl/tks_pkg.sv
// Shared types and constants of the top-k score selector.
// No dependencies; imported by the top level, the comparator and the checker.
package tks_pkg;

	localparam int LIMIT_W    = 6;
	localparam int RESULT_CAP = 32;

	localparam logic MODE_OFFER = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [31:0] hit_index;
		logic [30:0] hit_score;
		logic [15:0] hit_kind;
		logic [7:0]  hit_key;
	} tks_req_t;

	typedef struct packed {
		logic [31:0] out_index;
		logic [30:0] out_score;
		logic [15:0] out_kind;
		logic [7:0]  out_key;
		logic        is_empty;
		logic        overflowed;
		logic        last_of_run;
	} tks_res_t;

	// One kept hit as it sits in the store.
	typedef struct packed {
		logic [30:0] score;
		logic [31:0] index;
		logic [15:0] kind;
		logic [7:0]  key;
	} tks_entry_t;

endpackage

>>> hw/rtl/top_k_score_selector_top.sv
// Top-k score selector: sequencer around one store RAM and one shared comparator.
// Depends on tks_pkg, tks_ram and tks_rank.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. An offer
//   request (mode 0) carries one scored hit; a drain request (mode 1) emits the
//   kept hits best-first on res, one per res_stb pulse, last_of_run on the final.
//   cfg_we/cfg_wdata write keep_limit; write it only while busy is low.
// Operation (n = hits kept, count of the store):
//   Offer into a store below its limit: written at accept, busy stays low.
//   Offer into a full store: busy while it makes one RAM read per cycle over
//   the n kept hits to find the worst one, then one compare and replace.
//   Drain: result p follows a scan of slots p to n - 1 for the best hit; a
//   swap step moves that hit into slot p when it lies elsewhere. The RAM read
//   port paces each scan. An empty drain gives its one result the next cycle.
// Reset clears the hit count, overflow flag and keep_limit; the store contents
// are not cleared and need no clearing pass. Results last exactly one cycle:
// the receiver cannot stall them.
module top_k_score_selector_top import tks_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  tks_req_t           req,
	output tks_res_t           res,
	output logic               res_stb,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata
);

	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW1 = LIMIT_W + 1;
	localparam logic [CW-1:0]  CAP_C    = CW'(CAPACITY);
	localparam logic [LW1-1:0] CAP_L    = LW1'(CAPACITY);
	localparam logic [CW-1:0]  EMIT_MAX = CW'((CAPACITY < RESULT_CAP) ? CAPACITY : RESULT_CAP);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_OSCAN = 3'd1;
	localparam logic [2:0] S_OFIN  = 3'd2;
	localparam logic [2:0] S_DSCAN = 3'd3;
	localparam logic [2:0] S_DFIN  = 3'd4;
	localparam logic [2:0] S_DSWAP = 3'd5;

	logic [2:0]         state_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CW-1:0]      count_q;
	logic               ovf_q;
	logic [CW-1:0]      i_q;
	logic [AW-1:0]      p_q;
	logic [CW-1:0]      emit_q;
	logic               vld_s1;
	logic [AW-1:0]      idx_s1;
	tks_entry_t         cur_q;
	logic [AW-1:0]      cidx_q;
	tks_entry_t         pdata_q;
	tks_entry_t         hit_q;
	tks_res_t           res_q;
	logic               res_stb_q;

	logic               capped;
	logic [CW-1:0]      eff_lim;
	logic [CW-1:0]      n_lim;
	logic [CW-1:0]      emit_c;
	logic               accept;
	logic               has_room;
	tks_entry_t         hit_ent;
	tks_entry_t         rd_data;
	tks_entry_t         cmp_a;
	tks_entry_t         cmp_b;
	logic               better;
	logic               scanning;
	logic               issue;
	logic [AW-1:0]      last_addr;
	logic               last_rd;
	logic               first_rd;
	logic               take;
	logic [CW-1:0]      p_next;
	logic               drain_last;
	logic               we;
	logic [AW-1:0]      waddr;
	tks_entry_t         wdata;

	// Limit zero or above capacity falls back to the full store.
	assign capped   = (limit_q == '0) || ({1'b0, limit_q} > CAP_L);
	assign eff_lim  = capped ? CAP_C : CW'(limit_q);
	assign n_lim    = (count_q < eff_lim) ? count_q : eff_lim;
	assign emit_c   = (n_lim < EMIT_MAX) ? n_lim : EMIT_MAX;
	assign accept   = start && !busy;
	assign has_room = count_q < eff_lim;

	assign hit_ent = '{score: req.hit_score, index: req.hit_index,
		kind: req.hit_kind, key: req.hit_key};

	assign scanning  = (state_q == S_OSCAN) || (state_q == S_DSCAN);
	assign issue     = scanning && (i_q < count_q);
	assign last_addr = AW'(count_q - CW'(1));
	assign last_rd   = vld_s1 && (idx_s1 == last_addr);
	assign first_rd  = idx_s1 == p_q;
	assign p_next    = CW'(p_q) + CW'(1);
	assign drain_last = p_next == emit_q;

	// Operand routing for the shared comparator.
	always_comb begin
		case (state_q)
			S_OSCAN: begin
				cmp_a = cur_q;
				cmp_b = rd_data;
			end
			S_OFIN: begin
				cmp_a = hit_q;
				cmp_b = cur_q;
			end
			default: begin
				cmp_a = rd_data;
				cmp_b = cur_q;
			end
		endcase
	end

	tks_rank u_rank (
		.a        (cmp_a),
		.b        (cmp_b),
		.a_better (better)
	);

	// Offer scan hunts the worst hit, drain scan hunts the best one.
	assign take = vld_s1 && (first_rd || better);

	always_comb begin
		we    = 1'b0;
		waddr = cidx_q;
		wdata = pdata_q;
		case (state_q)
			S_IDLE: begin
				we    = accept && (req.mode == MODE_OFFER) && has_room;
				waddr = count_q[AW-1:0];
				wdata = hit_ent;
			end
			S_OFIN: begin
				we    = better;
				waddr = cidx_q;
				wdata = hit_q;
			end
			S_DFIN: begin
				we    = cidx_q != p_q;
				waddr = p_q;
				wdata = cur_q;
			end
			S_DSWAP: begin
				we    = 1'b1;
				waddr = cidx_q;
				wdata = pdata_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	tks_ram #(
		.WIDTH ($bits(tks_entry_t)),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (i_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			limit_q   <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			i_q       <= '0;
			p_q       <= '0;
			emit_q    <= '0;
			vld_s1    <= 1'b0;
			res_stb_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			vld_s1    <= issue;
			res_stb_q <= 1'b0;
			if (issue) begin
				i_q <= i_q + CW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						i_q <= '0;
						p_q <= '0;
						if (req.mode == MODE_OFFER) begin
							if (has_room) begin
								count_q <= count_q + CW'(1);
							end else begin
								state_q <= S_OSCAN;
								if (capped) begin
									ovf_q <= 1'b1;
								end
							end
						end else if (count_q == '0) begin
							res_stb_q <= 1'b1;
							ovf_q     <= 1'b0;
						end else begin
							emit_q  <= emit_c;
							state_q <= S_DSCAN;
						end
					end
				end
				S_OSCAN: begin
					if (last_rd) begin
						state_q <= S_OFIN;
					end
				end
				S_OFIN: begin
					state_q <= S_IDLE;
				end
				S_DSCAN: begin
					if (last_rd) begin
						state_q <= S_DFIN;
					end
				end
				S_DFIN, S_DSWAP: begin
					if (state_q == S_DFIN) begin
						res_stb_q <= 1'b1;
					end
					if ((state_q == S_DFIN) && (cidx_q != p_q)) begin
						state_q <= S_DSWAP;
					end else if (drain_last) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						// advance to the next output slot
						p_q     <= AW'(p_next);
						i_q     <= p_next;
						state_q <= S_DSCAN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= i_q[AW-1:0];
		if (take) begin
			cur_q  <= rd_data;
			cidx_q <= idx_s1;
			if (first_rd) begin
				pdata_q <= rd_data;
			end
		end
		if (accept) begin
			hit_q <= hit_ent;
		end
		if ((state_q == S_IDLE) && accept && (req.mode == MODE_DRAIN)) begin
			res_q <= '{out_index: '0, out_score: '0, out_kind: '0, out_key: '0,
				is_empty: 1'b1, overflowed: ovf_q, last_of_run: 1'b1};
		end else if (state_q == S_DFIN) begin
			res_q <= '{out_index: cur_q.index, out_score: cur_q.score,
				out_kind: cur_q.kind, out_key: cur_q.key, is_empty: 1'b0,
				overflowed: ovf_q, last_of_run: drain_last};
		end
	end

	assign busy    = state_q != S_IDLE;
	assign res     = res_q;
	assign res_stb = res_stb_q;

endmodule

>>> hw/rtl/tks_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/tks_rank.sv
// Shared ranking comparator: higher score wins, lower item index breaks ties.
// Depends on tks_pkg for the entry type.
module tks_rank import tks_pkg::*; (
	input  tks_entry_t a,
	input  tks_entry_t b,
	output logic       a_better
);

	always_comb begin
		if (a.score != b.score) begin
			a_better = a.score > b.score;
		end else begin
			a_better = a.index < b.index;
		end
	end

endmodule

>>> hw/rtl/tks_checker.sv
// Port-level checks of the top-k score selector, bound to its top level.
// Depends on tks_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tks_checker import tks_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input tks_req_t req,
	input tks_res_t res,
	input logic     res_stb
);

	// An empty set is reported by a single result.
	`ASSERT_NOW(a_empty_is_last, res_stb && res.is_empty, res.last_of_run)
	`ASSERT_NOW(a_empty_no_hit, res_stb && res.is_empty, (res.out_score == '0) && (res.out_index == '0))
	// Drain keeps the block busy until its final result.
	`ASSERT_NOW(a_run_holds_busy, res_stb && !res.last_of_run, busy)
	// Offers never produce a result.
	`ASSERT_NEXT(a_offer_silent, start && !busy && (req.mode == MODE_OFFER), !res_stb)

endmodule

bind top_k_score_selector_top tks_checker u_tks_checker (.*);
